[rtl/core/min_heap_key_update_unit_assert.svh]
// Assertion macros for the min-heap key update unit.
`ifndef MIN_HEAP_KEY_UPDATE_UNIT_ASSERT_SVH
`define MIN_HEAP_KEY_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on aclk and idle during reset.
`define MHKU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on aclk and idle during reset.
`define MHKU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MHKU_ASSERT_IMP(lbl, ante, cons)
`define MHKU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/mhku_pkg.sv]
// Shared constants, select codes and control structs of the min-heap key update unit.
package mhku_pkg;

    localparam int DEF_HEAP_DEPTH    = 64;
    localparam int DEF_PRIORITY_BITS = 32;
    localparam int SLOT_PORT_W       = 7;
    localparam int TAG_W             = 6;
    localparam int TAG_COUNT         = 64;
    localparam int ROOT_SLOT         = 1;

    localparam logic FUNC_PLACE  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Sources of the next slot index.
    localparam logic [2:0] IDX_MAP    = 3'd0;
    localparam logic [2:0] IDX_SLOT   = 3'd1;
    localparam logic [2:0] IDX_PARENT = 3'd2;
    localparam logic [2:0] IDX_LEFT   = 3'd3;
    localparam logic [2:0] IDX_RIGHT  = 3'd4;

    // Heap read address sources.
    localparam logic [2:0] RD_LEFT          = 3'd0;
    localparam logic [2:0] RD_RIGHT         = 3'd1;
    localparam logic [2:0] RD_PARENT        = 3'd2;
    localparam logic [2:0] RD_GRAND         = 3'd3;
    localparam logic [2:0] RD_LEFT_OF_LEFT  = 3'd4;
    localparam logic [2:0] RD_LEFT_OF_RIGHT = 3'd5;

    // Heap write data sources.
    localparam logic [1:0] WR_ITEM  = 2'd0;
    localparam logic [1:0] WR_RDATA = 2'd1;
    localparam logic [1:0] WR_CHILD = 2'd2;

    typedef struct packed {
        logic       load;
        logic       map_rd;
        logic       heap_rd;
        logic [2:0] rd_sel;
        logic       idx_ld;
        logic [2:0] idx_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       wr_at_slot;
        logic       child_ld;
        logic       out_ld;
    } mhku_cmd_t;

    typedef struct packed {
        logic func_update;
        logic slot_ok;
        logic idx_ok;
        logic idx_root;
        logic dn_ok;
        logic dn_ok_l;
        logic dn_ok_r;
        logic has_right;
        logic par_lt;
        logic par_gt;
        logic up_cont;
        logic left_win_now;
        logic left_win_reg;
        logic right_win;
    } mhku_status_t;

endpackage

[rtl/core/mhku_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mhku_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mhku_dpath.sv]
// Datapath of the min-heap key update unit: item registers, heap and map memories, compares.
module mhku_dpath
    import mhku_pkg::*;
#(
    parameter int HEAP_DEPTH    = DEF_HEAP_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
    input  logic                     aclk,
    input  logic                     s_func,
    input  logic [SLOT_PORT_W-1:0]   s_slot,
    input  logic [TAG_W-1:0]         s_item_tag,
    input  logic [PRIORITY_BITS-1:0] s_new_priority,
    input  logic [SLOT_PORT_W-1:0]   s_heap_count,
    input  mhku_cmd_t                cmd,
    output mhku_status_t             status,
    output logic [SLOT_PORT_W-1:0]   m_final_slot,
    output logic [TAG_W-1:0]         m_top_tag,
    output logic [PRIORITY_BITS-1:0] m_top_priority
);

    localparam int SLOT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int ADDR_W  = $clog2(HEAP_DEPTH);
    localparam int MAP_A_W = $clog2(TAG_COUNT);
    localparam int ENTRY_W = TAG_W + PRIORITY_BITS;
    localparam int WIDE_W  = SLOT_W + SLOT_PORT_W;
    localparam int KID_W   = SLOT_W + 2;

    logic                     func_reg;
    logic [SLOT_PORT_W-1:0]   slot_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [SLOT_W-1:0]        cnt_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [SLOT_W-1:0]        idx_next;
    logic [ENTRY_W-1:0]       child_reg;
    logic                     left_win_reg;
    logic [ENTRY_W-1:0]       root_reg;
    logic [SLOT_PORT_W-1:0]   final_reg;
    logic [TAG_W-1:0]         top_tag_reg;
    logic [PRIORITY_BITS-1:0] top_prio_reg;

    logic [WIDE_W-1:0]        cnt_wide;
    logic [SLOT_W-1:0]        cnt_sat;
    logic [WIDE_W-1:0]        slot_wide;
    logic [SLOT_W-1:0]        slot_idx;
    logic [WIDE_W-1:0]        idx_wide;

    logic [KID_W-1:0]         idx_k;
    logic [KID_W-1:0]         left_k;
    logic [KID_W-1:0]         right_k;
    logic [KID_W-1:0]         cnt_k;
    logic [KID_W-1:0]         half_k;
    logic [KID_W-1:0]         rd_slot;
    logic [KID_W-1:0]         rd_slot_m1;

    logic [ENTRY_W-1:0]       heap_rdata;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PRIORITY_BITS-1:0] best_prio;
    logic [SLOT_W-1:0]        map_rdata;

    logic [SLOT_W-1:0]        wr_slot;
    logic [SLOT_W-1:0]        wr_slot_m1;
    logic [ENTRY_W-1:0]       wr_data;
    logic [TAG_W-1:0]         wr_tag;

    // Input conversion: saturate the count, widen the slot for range checks.
    assign cnt_wide  = {{SLOT_W{1'b0}}, s_heap_count};
    assign cnt_sat   = (cnt_wide > WIDE_W'(HEAP_DEPTH)) ? SLOT_W'(HEAP_DEPTH)
                                                        : cnt_wide[SLOT_W-1:0];
    assign slot_wide = {{SLOT_W{1'b0}}, slot_reg};
    assign slot_idx  = slot_wide[SLOT_W-1:0];
    assign idx_wide  = {{SLOT_PORT_W{1'b0}}, idx_reg};

    assign idx_k   = {2'b00, idx_reg};
    assign left_k  = idx_k << 1;
    assign right_k = left_k | KID_W'(1);
    assign cnt_k   = {2'b00, cnt_reg};
    assign half_k  = cnt_k >> 1;

    assign rd_prio   = heap_rdata[PRIORITY_BITS-1:0];
    assign best_prio = left_win_reg ? child_reg[PRIORITY_BITS-1:0] : prio_reg;

    always_comb begin
        status              = '0;
        status.func_update  = (func_reg == FUNC_UPDATE);
        status.slot_ok      = (slot_wide != '0) && (slot_wide <= WIDE_W'(HEAP_DEPTH));
        status.idx_ok       = (idx_reg != '0) && (idx_reg <= SLOT_W'(HEAP_DEPTH));
        status.idx_root     = (idx_reg == SLOT_W'(ROOT_SLOT));
        status.dn_ok        = (idx_k <= half_k);
        status.dn_ok_l      = (left_k <= half_k);
        status.dn_ok_r      = (right_k <= half_k);
        status.has_right    = (right_k <= cnt_k);
        status.par_lt       = (rd_prio < prio_reg);
        status.par_gt       = (rd_prio > prio_reg);
        status.up_cont      = (idx_k >= KID_W'(4));
        status.left_win_now = (prio_reg >= rd_prio);
        status.left_win_reg = left_win_reg;
        status.right_win    = (best_prio >= rd_prio);
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_LEFT:          rd_slot = left_k;
            RD_RIGHT:         rd_slot = right_k;
            RD_PARENT:        rd_slot = idx_k >> 1;
            RD_GRAND:         rd_slot = idx_k >> 2;
            RD_LEFT_OF_LEFT:  rd_slot = left_k << 1;
            RD_LEFT_OF_RIGHT: rd_slot = right_k << 1;
            default:          rd_slot = left_k;
        endcase
    end
    assign rd_slot_m1 = rd_slot - KID_W'(1);

    always_comb begin
        case (cmd.wr_sel)
            WR_ITEM:  wr_data = {tag_reg, prio_reg};
            WR_RDATA: wr_data = heap_rdata;
            WR_CHILD: wr_data = child_reg;
            default:  wr_data = {tag_reg, prio_reg};
        endcase
    end
    assign wr_slot    = cmd.wr_at_slot ? slot_idx : idx_reg;
    assign wr_slot_m1 = wr_slot - SLOT_W'(1);
    assign wr_tag     = wr_data[ENTRY_W-1 -: TAG_W];

    always_comb begin
        case (cmd.idx_sel)
            IDX_MAP:    idx_next = map_rdata;
            IDX_SLOT:   idx_next = slot_idx;
            IDX_PARENT: idx_next = idx_reg >> 1;
            IDX_LEFT:   idx_next = left_k[SLOT_W-1:0];
            IDX_RIGHT:  idx_next = right_k[SLOT_W-1:0];
            default:    idx_next = idx_reg;
        endcase
    end

    // Every heap write moves an entry into a slot, so the map entry of
    // that entry's tag is rewritten with the same slot in the same cycle.
    mhku_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wr_slot_m1[ADDR_W-1:0]),
        .wdata (wr_data),
        .re    (cmd.heap_rd),
        .raddr (rd_slot_m1[ADDR_W-1:0]),
        .rdata (heap_rdata)
    );

    mhku_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TAG_COUNT)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wr_tag[MAP_A_W-1:0]),
        .wdata (wr_slot),
        .re    (cmd.map_rd),
        .raddr (tag_reg[MAP_A_W-1:0]),
        .rdata (map_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            slot_reg <= s_slot;
            tag_reg  <= s_item_tag;
            prio_reg <= s_new_priority;
            cnt_reg  <= cnt_sat;
        end
        if (cmd.idx_ld) begin
            idx_reg <= idx_next;
        end
        if (cmd.child_ld) begin
            child_reg    <= heap_rdata;
            left_win_reg <= status.left_win_now;
        end
        if (cmd.wr_en && (wr_slot == SLOT_W'(ROOT_SLOT))) begin
            root_reg <= wr_data;
        end
        if (cmd.out_ld) begin
            final_reg    <= idx_wide[SLOT_PORT_W-1:0];
            top_tag_reg  <= root_reg[ENTRY_W-1 -: TAG_W];
            top_prio_reg <= root_reg[PRIORITY_BITS-1:0];
        end
    end

    assign m_final_slot   = final_reg;
    assign m_top_tag      = top_tag_reg;
    assign m_top_priority = top_prio_reg;

endmodule

[rtl/core/mhku_ctrl.sv]
// Controller state machine of the min-heap key update unit.
module mhku_ctrl
    import mhku_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  mhku_status_t status,
    output mhku_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_POS    = 4'd2;
    localparam logic [3:0] ST_START  = 4'd3;
    localparam logic [3:0] ST_PAR    = 4'd4;
    localparam logic [3:0] ST_UP     = 4'd5;
    localparam logic [3:0] ST_DN_L   = 4'd6;
    localparam logic [3:0] ST_DN_R   = 4'd7;
    localparam logic [3:0] ST_PUT    = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.func_update || !status.slot_ok) begin
                    cmd.map_rd = 1'b1;
                    state_next = ST_POS;
                end else begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = WR_ITEM;
                    cmd.wr_at_slot = 1'b1;
                    cmd.idx_ld     = 1'b1;
                    cmd.idx_sel    = IDX_SLOT;
                    state_next     = ST_DONE;
                end
            end
            ST_POS: begin
                cmd.idx_ld  = 1'b1;
                cmd.idx_sel = IDX_MAP;
                state_next  = status.func_update ? ST_START : ST_DONE;
            end
            ST_START: begin
                if (!status.idx_ok) begin
                    state_next = ST_DONE;
                end else if (status.idx_root) begin
                    if (status.dn_ok) begin
                        cmd.heap_rd = 1'b1;
                        cmd.rd_sel  = RD_LEFT;
                        state_next  = ST_DN_L;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else begin
                    cmd.heap_rd = 1'b1;
                    cmd.rd_sel  = RD_PARENT;
                    state_next  = ST_PAR;
                end
            end
            ST_PAR, ST_UP: begin
                if (state_reg == ST_PAR && status.par_lt) begin
                    if (status.dn_ok) begin
                        cmd.heap_rd = 1'b1;
                        cmd.rd_sel  = RD_LEFT;
                        state_next  = ST_DN_L;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else if (status.par_gt) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_RDATA;
                    cmd.idx_ld  = 1'b1;
                    cmd.idx_sel = IDX_PARENT;
                    if (status.up_cont) begin
                        cmd.heap_rd = 1'b1;
                        cmd.rd_sel  = RD_GRAND;
                        state_next  = ST_UP;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_DN_L: begin
                cmd.child_ld = 1'b1;
                if (status.has_right) begin
                    cmd.heap_rd = 1'b1;
                    cmd.rd_sel  = RD_RIGHT;
                    state_next  = ST_DN_R;
                end else begin
                    if (status.left_win_now) begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_RDATA;
                        cmd.idx_ld  = 1'b1;
                        cmd.idx_sel = IDX_LEFT;
                    end
                    state_next = ST_PUT;
                end
            end
            ST_DN_R: begin
                if (status.right_win) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_RDATA;
                    cmd.idx_ld  = 1'b1;
                    cmd.idx_sel = IDX_RIGHT;
                    if (status.dn_ok_r) begin
                        cmd.heap_rd = 1'b1;
                        cmd.rd_sel  = RD_LEFT_OF_RIGHT;
                        state_next  = ST_DN_L;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else if (status.left_win_reg) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_CHILD;
                    cmd.idx_ld  = 1'b1;
                    cmd.idx_sel = IDX_LEFT;
                    if (status.dn_ok_l) begin
                        cmd.heap_rd = 1'b1;
                        cmd.rd_sel  = RD_LEFT_OF_LEFT;
                        state_next  = ST_DN_L;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ITEM;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_ld   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/core/min_heap_key_update_unit.sv]
// Top level of the min-heap key update unit: controller, datapath and checks.
//
// The unit keeps a 1-based binary min-heap of tagged priorities together with
// a tag-to-slot map. Items arrive on the s_ channel (valid/ready); each one
// yields exactly one result on the m_ channel (valid/ready), in order.
// A place item writes tag and priority into an in-range slot and records the
// slot in the map. An update item looks up the tag, sets its new priority and
// walks it down or up the heap, rewriting the map entry of every moved tag.
// The result carries the tag's final slot and the current root entry.
// Walking down reads the left and, where there is one, the right child of
// each level one after the other through the single read port of the heap
// memory; walking up reads one parent per level.
// One item is in work at a time; s_ready returns in the cycle after the
// result is loaded, so a new item is taken only once the last is through.
// A result waits in an output register while the receiver stalls, and the
// next item is still taken and worked on; only its own result waits.
// Reset (aresetn, synchronous, active low) returns control to idle and drops
// any pending result; heap and map contents are not cleared.
module min_heap_key_update_unit
    import mhku_pkg::*;
#(
    parameter int HEAP_DEPTH    = DEF_HEAP_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [SLOT_PORT_W-1:0]   s_slot,
    input  logic [TAG_W-1:0]         s_item_tag,
    input  logic [PRIORITY_BITS-1:0] s_new_priority,
    input  logic [SLOT_PORT_W-1:0]   s_heap_count,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SLOT_PORT_W-1:0]   m_final_slot,
    output logic [TAG_W-1:0]         m_top_tag,
    output logic [PRIORITY_BITS-1:0] m_top_priority
);

`include "min_heap_key_update_unit_assert.svh"

    mhku_cmd_t    cmd;
    mhku_status_t status;

    // The controller sequences an update through lookup, the heap walk and the
    // final write, a place through a write or lookup; it owns both handshakes.
    mhku_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the item being worked on, the two memories, the
    // root shadow copy and the result register.
    mhku_dpath #(
        .HEAP_DEPTH    (HEAP_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .s_func         (s_func),
        .s_slot         (s_slot),
        .s_item_tag     (s_item_tag),
        .s_new_priority (s_new_priority),
        .s_heap_count   (s_heap_count),
        .cmd            (cmd),
        .status         (status),
        .m_final_slot   (m_final_slot),
        .m_top_tag      (m_top_tag),
        .m_top_priority (m_top_priority)
    );

    // Only one item is in work: after a transfer in, the port closes.
    `MHKU_ASSERT_NXT(a_one_item, s_valid && s_ready, !s_ready)
    // A loaded result is offered on the next cycle.
    `MHKU_ASSERT_NXT(a_result_shown, cmd.out_ld, m_valid)
    // Heap writes at the walking index only hit slots inside the heap.
    `MHKU_ASSERT_IMP(a_wr_idx_ok, cmd.wr_en && !cmd.wr_at_slot, status.idx_ok)
    // Place writes only happen for an in-range slot.
    `MHKU_ASSERT_IMP(a_wr_slot_ok, cmd.wr_en && cmd.wr_at_slot, status.slot_ok)

endmodule

[tb/tb_min_heap_key_update_unit.sv]
// Self-checking testbench for the min-heap key update unit with a scoreboard class.
module tb_min_heap_key_update_unit
    import mhku_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Widths and sizes follow the block's default configuration.
    localparam int PW          = DEF_PRIORITY_BITS;
    localparam int SW          = SLOT_PORT_W;
    localparam int HEAP_SLOTS  = DEF_HEAP_DEPTH;
    // The slowest correct run is about 1120 items, each with the block's worst
    // case and the longest gap on both sides; this limit is several times that run.
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1100;

    // One result transfer: the tag's slot and the root entry after the item.
    typedef struct packed {
        logic [SW-1:0]    final_slot;
        logic [TAG_W-1:0] top_tag;
        logic [PW-1:0]    top_priority;
    } heap_answer_t;

    // The scoreboard mirrors the heap, the tag map and the queue of answers
    // that the block still owes. It is fed every accepted input transfer and
    // checks every accepted result transfer against the oldest answer.
    class heap_scoreboard;
        bit [PW-1:0]    prio_at [0:HEAP_SLOTS];
        bit [TAG_W-1:0] tag_at  [0:HEAP_SLOTS];
        bit [SW-1:0]    slot_of_tag [0:TAG_COUNT-1];
        heap_answer_t   answers [$];
        int             failures;
        int             shown;

        function void exchange_slots(int a, int b);
            bit [PW-1:0]    p;
            bit [TAG_W-1:0] t;
            p = prio_at[a];
            t = tag_at[a];
            prio_at[a] = prio_at[b];
            tag_at[a]  = tag_at[b];
            prio_at[b] = p;
            tag_at[b]  = t;
            slot_of_tag[tag_at[a]] = SW'(a);
            slot_of_tag[tag_at[b]] = SW'(b);
        endfunction

        // Move an entry toward the leaves; on ties it goes below the child,
        // and the right child wins a tie between the two children.
        function int sink(int idx, int cnt);
            int best;
            int c;
            while (idx <= cnt / 2) begin
                best = idx;
                c = idx * 2;
                if (c <= cnt && prio_at[best] >= prio_at[c]) best = c;
                c++;
                if (c <= cnt && prio_at[best] >= prio_at[c]) best = c;
                if (best == idx) break;
                exchange_slots(idx, best);
                idx = best;
            end
            return idx;
        endfunction

        // Move an entry toward the root while its parent is strictly greater.
        function int rise(int idx);
            while (idx >= 2) begin
                if (prio_at[idx / 2] > prio_at[idx]) begin
                    exchange_slots(idx, idx / 2);
                    idx = idx / 2;
                end else begin
                    break;
                end
            end
            return idx;
        endfunction

        function void note_item(logic func, logic [SW-1:0] slot, logic [TAG_W-1:0] tag,
                                logic [PW-1:0] prio, logic [SW-1:0] count);
            int           cnt;
            int           pos;
            heap_answer_t want;
            cnt = (count > HEAP_SLOTS) ? HEAP_SLOTS : int'(count);
            if (func == FUNC_PLACE) begin
                if (slot >= ROOT_SLOT && slot <= HEAP_SLOTS) begin
                    prio_at[slot] = prio;
                    tag_at[slot]  = tag;
                    slot_of_tag[tag] = slot;
                end
            end else begin
                pos = slot_of_tag[tag];
                if (pos >= ROOT_SLOT && pos <= HEAP_SLOTS) begin
                    prio_at[pos] = prio;
                    tag_at[pos]  = tag;
                    if (pos == ROOT_SLOT || prio_at[pos / 2] < prio) begin
                        pos = sink(pos, cnt);
                    end else begin
                        pos = rise(pos);
                    end
                    slot_of_tag[tag] = SW'(pos);
                end
            end
            want.final_slot   = slot_of_tag[tag];
            want.top_tag      = tag_at[ROOT_SLOT];
            want.top_priority = prio_at[ROOT_SLOT];
            answers.push_back(want);
        endfunction

        function void check_result(heap_answer_t got);
            heap_answer_t want;
            if (answers.size() == 0) begin
                failures++;
                if (shown < 10) begin
                    $display("unexpected result: slot %0d tag %0d priority %h",
                             got.final_slot, got.top_tag, got.top_priority);
                end
                shown++;
                return;
            end
            want = answers.pop_front();
            if (got.final_slot !== want.final_slot || got.top_tag !== want.top_tag ||
                    got.top_priority !== want.top_priority) begin
                failures++;
                if (shown < 10) begin
                    $display("mismatch: expected slot %0d tag %0d priority %h",
                             want.final_slot, want.top_tag, want.top_priority);
                    $display("          got slot %0d tag %0d priority %h",
                             got.final_slot, got.top_tag, got.top_priority);
                end
                shown++;
            end
        endfunction

        function int pending_count();
            return answers.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_func = FUNC_PLACE;
    logic [SW-1:0]    s_slot = '0;
    logic [TAG_W-1:0] s_item_tag = '0;
    logic [PW-1:0]    s_new_priority = '0;
    logic [SW-1:0]    s_heap_count = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [SW-1:0]    m_final_slot;
    logic [TAG_W-1:0] m_top_tag;
    logic [PW-1:0]    m_top_priority;

    heap_scoreboard sb;
    int             cycle_count = 0;

    // Stimulus bookkeeping. Slots are always placed as a contiguous run from
    // the root, so every slot that an update can read has been written, and a
    // heap count never reaches past that run.
    int filled = 0;
    bit tag_live [0:TAG_COUNT-1];
    bit sender_steady = 1'b0;

    min_heap_key_update_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot         (s_slot),
        .s_item_tag     (s_item_tag),
        .s_new_priority (s_new_priority),
        .s_heap_count   (s_heap_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_final_slot   (m_final_slot),
        .m_top_tag      (m_top_tag),
        .m_top_priority (m_top_priority)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small values collide often and so exercise the tie rules.
    function automatic logic [PW-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return PW'($urandom_range(0, 15));
            6: return PW'($urandom_range(0, 1000));
            default: return PW'($urandom);
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_live_tag();
        int t;
        do t = $urandom_range(0, TAG_COUNT - 1); while (!tag_live[t]);
        return TAG_W'(t);
    endfunction

    // Heap counts stay within the placed run; only a full heap may see counts
    // above the depth, which the block saturates.
    function automatic logic [SW-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return SW'(filled);
        if (r == 8 && filled == HEAP_SLOTS) return SW'($urandom_range(HEAP_SLOTS + 1, 127));
        return SW'($urandom_range(0, filled));
    endfunction

    // Present one item and hold it until the block takes it. The valid line
    // is lowered only when a gap comes first, so it never drops and rises
    // again within one time step.
    task automatic send_item(input logic func, input logic [SW-1:0] slot,
                             input logic [TAG_W-1:0] tag, input logic [PW-1:0] prio,
                             input logic [SW-1:0] count);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_slot         <= slot;
        s_item_tag     <= tag;
        s_new_priority <= prio;
        s_heap_count   <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(func, slot, tag, prio, count);
        if (func == FUNC_PLACE && slot >= ROOT_SLOT && slot <= HEAP_SLOTS) begin
            tag_live[tag] = 1'b1;
            if (slot == filled + 1) filled++;
        end
    endtask

    task automatic place(input int slot, input int tag, input logic [PW-1:0] prio);
        send_item(FUNC_PLACE, SW'(slot), TAG_W'(tag), prio, SW'($urandom_range(0, 127)));
    endtask

    task automatic update(input int tag, input logic [PW-1:0] prio, input int count);
        send_item(FUNC_UPDATE, SW'($urandom_range(0, 127)), TAG_W'(tag), prio, SW'(count));
    endtask

    // Stop sending until the block has returned every result it owes.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_count() != 0);
    endtask

    // Result side: every accepted result transfer goes to the scoreboard.
    // Values are read right after the edge, before any register updates.
    initial begin
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result('{m_final_slot, m_top_tag, m_top_priority});
            end
        end
    end

    // Receiver stalls: short ones mostly, some long, and stretches where it
    // stays ready throughout.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("min_heap_key_update_unit test failed");
            $finish;
        end
    end

    initial begin
        int r;
        sb = new;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Build a seven-slot heap. The root is placed first, since every
        // result reports the root entry. The priorities include both
        // extremes and pairs of equal siblings.
        place(1, 0, 32'h8000_0000);
        place(2, 63, '0);
        place(3, 21, '1);
        place(4, 42, 7);
        place(5, 5, 7);
        place(6, 9, 100);
        place(7, 12, 100);

        // Places to slots outside the heap write nothing; the result reports
        // the tag's existing map entry.
        place(0, 5, 1);
        place(127, 63, 2);
        place(65, 21, 3);

        // The root moves down one level and stops above its children.
        update(0, 1, 7);
        // The parent is smaller, so the entry sinks; it ties with both
        // children and the right one takes the tie.
        update(0, 7, 7);
        // A leaf rises and stops below a parent of equal priority.
        update(9, 0, 7);
        // A heap count of zero does not matter for an upward move.
        update(42, 0, 0);
        // At the root with a heap count below the slot, nothing moves.
        update(63, '1, 0);
        // The largest priority sinks all the way to a leaf.
        update(63, '1, 7);
        // Overwrite slot 7, then update tag 12, which the last sink moved from slot 7
        // to slot 3: the update claims slot 7 again.
        place(7, 40, 3);
        update(12, 200, 7);
        update(21, 0, 3);

        // Hold off until every result is in before the random part.
        wait_drained();

        // Random part: mostly updates on a heap that keeps growing, with
        // places into new and existing slots and some out-of-range places.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) sender_steady = ($urandom_range(0, 9) < 3);
            if (i % 275 == 274) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 15 && filled < HEAP_SLOTS) begin
                place(filled + 1, $urandom_range(0, TAG_COUNT - 1), pick_priority());
            end else if (r < 22) begin
                place($urandom_range(1, filled), $urandom_range(0, TAG_COUNT - 1),
                      pick_priority());
            end else if (r < 27) begin
                place($urandom_range(0, 1) ? 0 : $urandom_range(HEAP_SLOTS + 1, 127),
                      pick_live_tag(), pick_priority());
            end else begin
                send_item(FUNC_UPDATE, SW'($urandom_range(0, 127)), pick_live_tag(),
                          pick_priority(), pick_count());
            end
        end

        // Let the last results come back, then keep watching for any result that
        // should not be there.
        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.pending_count() == 0) begin
            $display("min_heap_key_update_unit test passed");
        end else begin
            $display("min_heap_key_update_unit test failed");
        end
        $finish;
    end

endmodule
